// ----- rtl/core/jse_pkg.sv -----
package jse_pkg;

    // Escape classes of a source byte
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SHORT,
        ESC_UNICODE
    } t_esc_kind;

    // Position inside an output run (at most six bytes)
    typedef logic [2:0] t_run_idx;

    localparam logic [7:0] BACKSLASH       = 8'h5C;
    localparam logic [7:0] DQUOTE          = 8'h22;
    localparam logic [7:0] CHAR_U          = 8'h75;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;

    localparam t_run_idx IDX_LEAD    = 3'd0;
    localparam t_run_idx IDX_SECOND  = 3'd1;
    localparam t_run_idx IDX_ZERO_HI = 3'd2;
    localparam t_run_idx IDX_ZERO_LO = 3'd3;
    localparam t_run_idx IDX_HEX_HI  = 3'd4;
    localparam t_run_idx IDX_HEX_LO  = 3'd5;

    // Letter after the backslash for a short escape, zero if there is none
    function automatic logic [7:0] short_letter(input logic [7:0] c);
        logic [7:0] l;
        case (c)
            8'h0A:     l = 8'h6E;   // n
            8'h0D:     l = 8'h72;   // r
            8'h0C:     l = 8'h66;   // f
            8'h09:     l = 8'h74;   // t
            8'h08:     l = 8'h62;   // b
            BACKSLASH: l = BACKSLASH;
            DQUOTE:    l = DQUOTE;
            default:   l = 8'h00;
        endcase
        return l;
    endfunction

    // Classify a source byte
    function automatic t_esc_kind esc_kind(input logic [7:0] c);
        t_esc_kind k;
        if (short_letter(c) != 8'h00) begin
            k = ESC_SHORT;
        end else if (c < FIRST_PRINTABLE) begin
            k = ESC_UNICODE;
        end else begin
            k = ESC_NONE;
        end
        return k;
    endfunction

    // Lowercase hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10) begin
            d = CHAR_ZERO + {4'd0, n};
        end else begin
            d = 8'h57 + {4'd0, n};  // 'a' - 10
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/json_string_escaper_unit.sv -----
// JSON string escaper. Each accepted item is one source byte; the block emits
// its escaped form as a run of output items, the last marked by o_run_last.
// Ordinary bytes (0x20 and up, other than quote and backslash) give one item,
// the seven short escapes give two, other control bytes give six (\u00xx).
// Throughput is one output item per cycle while i_out_stall is low: a byte
// that passes through lets a new item be accepted every cycle, while an
// escaped byte holds the input stage until its whole run has gone out through
// the output register. An accepted item passes through the input stage and
// then the output register. The block keeps no state between items.
module json_string_escaper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import jse_pkg::*;

    logic      r_a_valid;
    logic [7:0] r_a_byte;
    t_esc_kind r_a_kind;
    t_run_idx  r_idx;

    logic      r_out_valid;
    logic [7:0] r_out_byte;
    logic      r_out_last;

    logic      out_free;
    logic      a_fire;
    logic      a_last;
    logic      a_done;
    logic      in_take;
    logic [7:0] n_byte;
    logic [7:0] letter;

    // Handshake between the input stage and the output register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_fire     = r_a_valid && out_free;
    assign a_done     = a_fire && a_last;
    assign o_in_stall = r_a_valid && !a_done;
    assign in_take    = i_in_valid && !o_in_stall;

    assign letter = short_letter(r_a_byte);

    // Select the byte at the current run position and flag the end of the run
    always_comb begin
        n_byte = BACKSLASH;
        a_last = 1'b0;
        case (r_a_kind)
            ESC_NONE: begin
                n_byte = r_a_byte;
                a_last = 1'b1;
            end
            ESC_SHORT: begin
                n_byte = (r_idx == IDX_LEAD) ? BACKSLASH : letter;
                a_last = (r_idx != IDX_LEAD);
            end
            ESC_UNICODE: begin
                case (r_idx)
                    IDX_LEAD:    n_byte = BACKSLASH;
                    IDX_SECOND:  n_byte = CHAR_U;
                    IDX_ZERO_HI: n_byte = CHAR_ZERO;
                    IDX_ZERO_LO: n_byte = CHAR_ZERO;
                    IDX_HEX_HI:  n_byte = hex_digit(r_a_byte[7:4]);
                    default:     n_byte = hex_digit(r_a_byte[3:0]);
                endcase
                a_last = (r_idx == IDX_HEX_LO);
            end
            default: begin
                n_byte = r_a_byte;
                a_last = 1'b1;
            end
        endcase
    end

    // Input stage: capture an item, advance through its run, drop when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_idx     <= IDX_LEAD;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
            r_idx     <= IDX_LEAD;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
            r_idx     <= IDX_LEAD;
        end else if (a_fire) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Input payload, classified on capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_byte <= i_in_byte;
            r_a_kind <= esc_kind(i_in_byte);
        end
    end

    // Output register: load a new item or hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_out_byte <= n_byte;
            r_out_last <= a_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

    // A run in progress at the output still has its source item held
    a_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_a_valid)
        else $error("output run open without a held source item");

    // Only escaped items advance past the first run position
    a_idx_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_idx != IDX_LEAD |-> r_a_kind != ESC_NONE)
        else $error("plain byte advanced beyond one output item");

    // Run position stays within the longest escape
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx == IDX_LEAD || r_idx == IDX_SECOND || r_idx == IDX_ZERO_HI ||
        r_idx == IDX_ZERO_LO || r_idx == IDX_HEX_HI || r_idx == IDX_HEX_LO)
        else $error("run position out of range");

    // A stalled full output blocks new items while one is held
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && r_a_valid |-> o_in_stall)
        else $error("item accepted while output stalled");

endmodule
